@@ hw/rtl/bilinear_rgba_image_scaler_macros.svh @@
// Assertion macros for the scaler top level.
`ifndef BILINEAR_RGBA_IMAGE_SCALER_MACROS_SVH
`define BILINEAR_RGBA_IMAGE_SCALER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BRS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define BRS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/brs_pkg.sv @@
// Shared constants, types and codes for the RGBA scaler.
package brs_pkg;

   localparam int MAX_W       = 256;
   localparam int MAX_H       = 256;
   localparam int COL_W       = $clog2(MAX_W);
   localparam int ROW_W       = $clog2(MAX_H);
   localparam int SIZE_W      = 9;
   localparam int STEP_W      = 25;
   localparam int RCOORD_W    = 12;
   localparam int PROD_W      = STEP_W + RCOORD_W;
   localparam int FRAC_W      = 16;
   localparam int INT_W       = PROD_W - FRAC_W;
   localparam int BANK_AW     = (COL_W - 1) + (ROW_W - 1);
   localparam int BANK_DEPTH  = 2 ** BANK_AW;
   localparam int NUM_BANKS   = 4;
   localparam int NUM_LANES   = 4;

   typedef logic [7:0]  chan_type;
   typedef logic [31:0] pixel_type;

   typedef enum logic [2:0] {
      REG_STEP_X        = 3'd0,
      REG_STEP_Y        = 3'd1,
      REG_SOURCE_WIDTH  = 3'd2,
      REG_SOURCE_HEIGHT = 3'd3,
      REG_SMOOTH_ENABLE = 3'd4,
      REG_MIRROR_X      = 3'd5,
      REG_MIRROR_Y      = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [STEP_W-1:0] step_x;
      logic [STEP_W-1:0] step_y;
      logic [COL_W-1:0]  w_m1;
      logic [ROW_W-1:0]  h_m1;
      logic              smooth;
      logic              mirror_x;
      logic              mirror_y;
   } geom_type;

   typedef struct packed {
      logic [COL_W-1:0]  ix0;
      logic [COL_W-1:0]  ix1;
      logic [ROW_W-1:0]  iy0;
      logic [ROW_W-1:0]  iy1;
      logic [FRAC_W-1:0] fx;
      logic [FRAC_W-1:0] fy;
   } coord_type;

   typedef struct packed {
      logic              wr_en;
      logic [COL_W-1:0]  wr_x;
      logic [ROW_W-1:0]  wr_y;
      pixel_type         wr_data;
      logic              rd_en;
   } store_ctl_type;

   typedef struct packed {
      pixel_type p00;
      pixel_type p01;
      pixel_type p10;
      pixel_type p11;
   } quad_type;

endpackage

@@ hw/rtl/brs_addr.sv @@
// Source coordinate generator: step multiply, clamp to image, mirror.
module brs_addr (
   input  logic                               clock,
   input  logic                               advance,
   input  logic [brs_pkg::RCOORD_W-1:0]       render_x,
   input  logic [brs_pkg::RCOORD_W-1:0]       render_y,
   input  brs_pkg::geom_type                  geom,
   output brs_pkg::coord_type                 coord
);

   logic [brs_pkg::PROD_W-1:0] prod_x_ff, prod_x_in;
   logic [brs_pkg::PROD_W-1:0] prod_y_ff, prod_y_in;
   brs_pkg::coord_type         clamp_ff, clamp_in;
   brs_pkg::coord_type         mir_ff, mir_in;
   logic [brs_pkg::INT_W-1:0]  px_int, py_int;

   assign prod_x_in = brs_pkg::PROD_W'(render_x) * brs_pkg::PROD_W'(geom.step_x);
   assign prod_y_in = brs_pkg::PROD_W'(render_y) * brs_pkg::PROD_W'(geom.step_y);

   // clamp integer part to the image, neighbour one step on (clamped)
   always_comb begin
      px_int = prod_x_ff[brs_pkg::PROD_W-1:brs_pkg::FRAC_W];
      py_int = prod_y_ff[brs_pkg::PROD_W-1:brs_pkg::FRAC_W];
      clamp_in.ix0 = (px_int >= brs_pkg::INT_W'(geom.w_m1)) ? geom.w_m1
                                                            : px_int[brs_pkg::COL_W-1:0];
      clamp_in.iy0 = (py_int >= brs_pkg::INT_W'(geom.h_m1)) ? geom.h_m1
                                                            : py_int[brs_pkg::ROW_W-1:0];
      clamp_in.ix1 = (clamp_in.ix0 == geom.w_m1) ? geom.w_m1 : clamp_in.ix0 + 1'b1;
      clamp_in.iy1 = (clamp_in.iy0 == geom.h_m1) ? geom.h_m1 : clamp_in.iy0 + 1'b1;
      // nearest mode: all four taps land on the nearest pixel
      if (!geom.smooth) begin
         clamp_in.ix1 = clamp_in.ix0;
         clamp_in.iy1 = clamp_in.iy0;
      end
      // zero fraction makes the blend return the nearest pixel
      clamp_in.fx  = geom.smooth ? prod_x_ff[brs_pkg::FRAC_W-1:0] : '0;
      clamp_in.fy  = geom.smooth ? prod_y_ff[brs_pkg::FRAC_W-1:0] : '0;
   end

   always_comb begin
      mir_in     = clamp_ff;
      if (geom.mirror_x) begin
         mir_in.ix0 = geom.w_m1 - clamp_ff.ix0;
         mir_in.ix1 = geom.w_m1 - clamp_ff.ix1;
      end
      if (geom.mirror_y) begin
         mir_in.iy0 = geom.h_m1 - clamp_ff.iy0;
         mir_in.iy1 = geom.h_m1 - clamp_ff.iy1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         clamp_ff  <= clamp_in;
         mir_ff    <= mir_in;
      end
   end

   assign coord = mir_ff;

endmodule

@@ hw/rtl/brs_store.sv @@
// Frame store split in four banks by column and row parity.
module brs_store (
   input  logic                  clock,
   input  logic                  advance,
   input  brs_pkg::store_ctl_type ctl,
   input  brs_pkg::coord_type     coord,
   output brs_pkg::quad_type      quad
);

   logic [brs_pkg::NUM_BANKS-1:0][brs_pkg::BANK_AW-1:0] rd_addr;
   logic [brs_pkg::NUM_BANKS-1:0][31:0]                 rd_q;
   logic [1:0]         sel00_ff, sel01_ff, sel10_ff, sel11_ff;
   logic [brs_pkg::BANK_AW-1:0] wr_addr;
   logic [1:0]                  wr_bank;

   assign wr_addr = {ctl.wr_y[brs_pkg::ROW_W-1:1], ctl.wr_x[brs_pkg::COL_W-1:1]};
   assign wr_bank = {ctl.wr_y[0], ctl.wr_x[0]};

   // bank index = {row parity, column parity}; neighbours never collide
   always_comb begin
      for (int b = 0; b < brs_pkg::NUM_BANKS; b++) begin
         logic [brs_pkg::COL_W-1:0] col;
         logic [brs_pkg::ROW_W-1:0] row;
         col = (coord.ix0[0] == b[0]) ? coord.ix0 : coord.ix1;
         row = (coord.iy0[0] == b[1]) ? coord.iy0 : coord.iy1;
         rd_addr[b] = {row[brs_pkg::ROW_W-1:1], col[brs_pkg::COL_W-1:1]};
      end
   end

   for (genvar b = 0; b < brs_pkg::NUM_BANKS; b++) begin : g_bank
      brs_pkg::pixel_type mem [brs_pkg::BANK_DEPTH];
      brs_pkg::pixel_type rd_q_ff;
      always_ff @(posedge clock) begin
         if (ctl.wr_en && wr_bank == 2'(b)) begin
            mem[wr_addr] <= ctl.wr_data;
         end
         if (ctl.rd_en) begin
            rd_q_ff <= mem[rd_addr[b]];
         end
      end
      assign rd_q[b] = rd_q_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sel00_ff <= {coord.iy0[0], coord.ix0[0]};
         sel01_ff <= {coord.iy0[0], coord.ix1[0]};
         sel10_ff <= {coord.iy1[0], coord.ix0[0]};
         sel11_ff <= {coord.iy1[0], coord.ix1[0]};
      end
   end

   assign quad.p00 = rd_q[sel00_ff];
   assign quad.p01 = rd_q[sel01_ff];
   assign quad.p10 = rd_q[sel10_ff];
   assign quad.p11 = rd_q[sel11_ff];

endmodule

@@ hw/rtl/brs_lane.sv @@
// One channel lane: two horizontal lerps, then one vertical lerp.
module brs_lane (
   input  logic                        clock,
   input  logic                        advance,
   input  brs_pkg::chan_type           c00,
   input  brs_pkg::chan_type           c01,
   input  brs_pkg::chan_type           c10,
   input  brs_pkg::chan_type           c11,
   input  logic [brs_pkg::FRAC_W-1:0]  fx,
   input  logic [brs_pkg::FRAC_W-1:0]  fy,
   output brs_pkg::chan_type           result
);

   logic signed [8:0]  d1, d2, d3;
   logic signed [16:0] fxs, fys;
   logic signed [25:0] m1_ff, m1_in, m2_ff, m2_in, m3_ff, m3_in;
   brs_pkg::chan_type  a_ff, c_ff, t1_ff, t1_in, t2_ff, t2_in, t1b_ff;
   logic [brs_pkg::FRAC_W-1:0] fy_ff, fy2_ff;

   assign fxs   = signed'({1'b0, fx});
   assign d1    = signed'({1'b0, c01}) - signed'({1'b0, c00});
   assign d2    = signed'({1'b0, c11}) - signed'({1'b0, c10});
   assign m1_in = d1 * fxs;
   assign m2_in = d2 * fxs;

   // floor shift by 16 then byte wrap: bits [23:16] of the product
   assign t1_in = m1_ff[23:16] + a_ff;
   assign t2_in = m2_ff[23:16] + c_ff;

   assign fys   = signed'({1'b0, fy2_ff});
   assign d3    = signed'({1'b0, t2_ff}) - signed'({1'b0, t1_ff});
   assign m3_in = d3 * fys;

   always_ff @(posedge clock) begin
      if (advance) begin
         m1_ff  <= m1_in;
         m2_ff  <= m2_in;
         a_ff   <= c00;
         c_ff   <= c10;
         fy_ff  <= fy;
         t1_ff  <= t1_in;
         t2_ff  <= t2_in;
         fy2_ff <= fy_ff;
         m3_ff  <= m3_in;
         t1b_ff <= t1_ff;
      end
   end

   assign result = m3_ff[23:16] + t1b_ff;

endmodule

@@ hw/rtl/bilinear_rgba_image_scaler.sv @@
// Top level of the bilinear / nearest RGBA image scaler.
// Usage:
//   req channel carries one transaction per item. tuser[0] is the opcode:
//   0 loads a source pixel into the frame store, 1 renders a destination
//   pixel. Load transactions produce nothing on rsp; each render produces
//   exactly one rsp transaction with the RGBA result, in order.
//   The csr APB port holds step, size, smooth and mirror settings; write it
//   only while no render is in flight.
// Throughput: one transaction per clock while rsp is not stalled, loads and
//   renders mixed freely. The frame store is four banks split by column/row
//   parity, so the four bilinear neighbours are read in the same cycle, one port per bank.
// Pipeline: nine register stages (input register, multiply, clamp,
//   mirror, store read, three lane stages, output reg).
// Reset: control and configuration return to defaults (step 1.0, 256x256,
//   nearest, no mirror). Store contents are undefined until loaded.
// Stall: when rsp_tvalid is high and rsp_tready low the whole pipeline
//   holds and req_tready drops; bubbles do not hold the pipe.
module bilinear_rgba_image_scaler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // load_x, load_y, load_red, load_green, load_blue, load_alpha, render_x, render_y
   input  logic [71:0] req_tdata,
   // opcode
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_red, out_green, out_blue, out_alpha
   output logic [31:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   `include "bilinear_rgba_image_scaler_macros.svh"

   // configuration registers
   logic [brs_pkg::STEP_W-1:0] step_x_ff, step_y_ff;
   logic [brs_pkg::SIZE_W-1:0] width_ff, height_ff;
   logic                       smooth_ff, mirror_x_ff, mirror_y_ff;
   logic                       csr_wr;
   brs_pkg::reg_index_type     csr_idx;
   brs_pkg::geom_type          geom;

   // pipeline control: valid bits per stage and render flags
   logic       advance;
   logic [3:0] vld_ff;      // stages 1..4 (input reg .. mirror output)
   logic [3:0] rnd_ff;      // render flag per stage
   logic [3:0] lane_vld_ff; // store read, lane stages 1..3
   logic       rsp_tvalid_ff, rsp_tvalid_in;
   logic [31:0] rsp_tdata_ff, rsp_tdata_in;

   // payload carried beside the coordinate unit for loads
   logic [71:0]               s1_data_ff;
   logic [brs_pkg::COL_W-1:0] ld_x_ff [3];
   logic [brs_pkg::ROW_W-1:0] ld_y_ff [3];
   brs_pkg::pixel_type        ld_px_ff [3];

   brs_pkg::coord_type    coord;
   brs_pkg::store_ctl_type sctl;
   brs_pkg::quad_type     quad;
   brs_pkg::coord_type    coord_q_ff;
   brs_pkg::chan_type     lane_out [brs_pkg::NUM_LANES];

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = brs_pkg::reg_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_x_ff   <= brs_pkg::STEP_W'(65536);
         step_y_ff   <= brs_pkg::STEP_W'(65536);
         width_ff    <= brs_pkg::SIZE_W'(256);
         height_ff   <= brs_pkg::SIZE_W'(256);
         smooth_ff   <= 1'b0;
         mirror_x_ff <= 1'b0;
         mirror_y_ff <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            brs_pkg::REG_STEP_X:        step_x_ff   <= csr_pwdata[brs_pkg::STEP_W-1:0];
            brs_pkg::REG_STEP_Y:        step_y_ff   <= csr_pwdata[brs_pkg::STEP_W-1:0];
            brs_pkg::REG_SOURCE_WIDTH:  width_ff    <= csr_pwdata[brs_pkg::SIZE_W-1:0];
            brs_pkg::REG_SOURCE_HEIGHT: height_ff   <= csr_pwdata[brs_pkg::SIZE_W-1:0];
            brs_pkg::REG_SMOOTH_ENABLE: smooth_ff   <= csr_pwdata[0];
            brs_pkg::REG_MIRROR_X:      mirror_x_ff <= csr_pwdata[0];
            brs_pkg::REG_MIRROR_Y:      mirror_y_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         brs_pkg::REG_STEP_X:        csr_prdata = 32'(step_x_ff);
         brs_pkg::REG_STEP_Y:        csr_prdata = 32'(step_y_ff);
         brs_pkg::REG_SOURCE_WIDTH:  csr_prdata = 32'(width_ff);
         brs_pkg::REG_SOURCE_HEIGHT: csr_prdata = 32'(height_ff);
         brs_pkg::REG_SMOOTH_ENABLE: csr_prdata = 32'(smooth_ff);
         brs_pkg::REG_MIRROR_X:      csr_prdata = 32'(mirror_x_ff);
         brs_pkg::REG_MIRROR_Y:      csr_prdata = 32'(mirror_y_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // size of zero acts as one, oversize acts as the maximum; keep size-1
   always_comb begin
      geom.step_x   = step_x_ff;
      geom.step_y   = step_y_ff;
      geom.smooth   = smooth_ff;
      geom.mirror_x = mirror_x_ff;
      geom.mirror_y = mirror_y_ff;
      if (width_ff == '0)
         geom.w_m1 = '0;
      else if (width_ff > brs_pkg::SIZE_W'(brs_pkg::MAX_W))
         geom.w_m1 = brs_pkg::COL_W'(brs_pkg::MAX_W - 1);
      else
         geom.w_m1 = brs_pkg::COL_W'(width_ff - 1'b1);
      if (height_ff == '0)
         geom.h_m1 = '0;
      else if (height_ff > brs_pkg::SIZE_W'(brs_pkg::MAX_H))
         geom.h_m1 = brs_pkg::ROW_W'(brs_pkg::MAX_H - 1);
      else
         geom.h_m1 = brs_pkg::ROW_W'(height_ff - 1'b1);
   end

   // ---------------- pipeline control ----------------
   // whole pipe moves unless a finished result is stuck at the output
   assign advance    = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         rnd_ff      <= '0;
         lane_vld_ff <= '0;
      end else if (advance) begin
         vld_ff      <= {vld_ff[2:0], req_tvalid};
         rnd_ff      <= {rnd_ff[2:0], req_tuser[0]};
         lane_vld_ff <= {lane_vld_ff[2:0], vld_ff[3] && rnd_ff[3]};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_data_ff  <= req_tdata;
         ld_x_ff[0]  <= s1_data_ff[7:0];
         ld_y_ff[0]  <= s1_data_ff[15:8];
         ld_px_ff[0] <= s1_data_ff[47:16];
         ld_x_ff[1]  <= ld_x_ff[0];
         ld_y_ff[1]  <= ld_y_ff[0];
         ld_px_ff[1] <= ld_px_ff[0];
         ld_x_ff[2]  <= ld_x_ff[1];
         ld_y_ff[2]  <= ld_y_ff[1];
         ld_px_ff[2] <= ld_px_ff[1];
         coord_q_ff  <= coord;
      end
   end

   // ---------------- coordinate unit ----------------
   brs_addr u_addr (
      .clock    (clock),
      .advance  (advance),
      .render_x (s1_data_ff[59:48]),
      .render_y (s1_data_ff[71:60]),
      .geom     (geom),
      .coord    (coord)
   );

   // ---------------- banked frame store ----------------
   // loads write at the same stage renders read, so order is kept
   always_comb begin
      sctl.wr_en   = advance && vld_ff[3] && !rnd_ff[3];
      sctl.wr_x    = ld_x_ff[2];
      sctl.wr_y    = ld_y_ff[2];
      sctl.wr_data = ld_px_ff[2];
      sctl.rd_en   = advance;
   end

   brs_store u_store (
      .clock   (clock),
      .advance (advance),
      .ctl     (sctl),
      .coord   (coord),
      .quad    (quad)
   );

   // ---------------- channel lanes ----------------
   for (genvar k = 0; k < brs_pkg::NUM_LANES; k++) begin : g_lane
      brs_lane u_lane (
         .clock   (clock),
         .advance (advance),
         .c00     (quad.p00[8*k +: 8]),
         .c01     (quad.p01[8*k +: 8]),
         .c10     (quad.p10[8*k +: 8]),
         .c11     (quad.p11[8*k +: 8]),
         .fx      (coord_q_ff.fx),
         .fy      (coord_q_ff.fy),
         .result  (lane_out[k])
      );
   end

   // ---------------- merge into the output register ----------------
   assign rsp_tdata_in  = {lane_out[3], lane_out[2], lane_out[1], lane_out[0]};
   assign rsp_tvalid_in = advance ? lane_vld_ff[3] : rsp_tvalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // ---------------- assertions ----------------
   `BRS_ASSERT_IMP(a_stall_blocks_req, clock, reset, rsp_tvalid_ff && !rsp_tready, !req_tready, "req accepted during output stall")
   `BRS_ASSERT_NXT(a_load_no_render, clock, reset, req_tvalid && req_tready && !req_tuser[0], vld_ff[0] && !rnd_ff[0], "load entered pipe as render")
   `BRS_ASSERT_NXT(a_hold_lanes, clock, reset, !advance, $stable(lane_vld_ff) && $stable(vld_ff), "pipeline moved while stalled")
   `BRS_ASSERT_IMP(a_no_write_on_stall, clock, reset, !advance, !sctl.wr_en, "store written during stall")

endmodule
